// File: hw/rtl/nmf_pkg.sv
// Shared types and constants of the 3x3 neighbour mean filter.
// Used by every filter module but nmf_ram, and by the testbench; no dependencies.

package nmf_pkg;

    // Default sizes, handed to the top level parameters
    localparam int NMF_MAX_WIDTH  = 1024;
    localparam int NMF_PIXEL_BITS = 16;

    // Register widths and counters
    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 12;
    localparam int ROW_BITS      = FH_BITS + 1;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;

    // Register reset values
    localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(4);
    localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(4);

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    // Item kinds carried on s_tuser
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Per-transaction control handed from the sequencer to the window unit
    typedef struct packed {
        logic shift;        // window and line stores advance
        logic emit;         // this transaction produces a result
        logic first_col;    // result belongs to the last column of a row
        logic second_col;   // result belongs to the first column of a row
        logic width_one;    // frame is a single column wide
        logic top_edge;     // replicate the centre row upward
        logic bottom_edge;  // replicate the centre row downward
        logic frame_end;    // result of the frame's last pixel
    } nmf_ctrl_t;

endpackage

// File: hw/rtl/nmf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old contents.

module nmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read the array
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/nmf_line_store.sv
// Upper and middle line stores of the filter, with write-to-read forwarding.
// Depends on nmf_ram and nmf_pkg.

module nmf_line_store
    import nmf_pkg::*;
#(
    parameter int MAX_WIDTH  = NMF_MAX_WIDTH,
    parameter int PIXEL_BITS = NMF_PIXEL_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,       // column advances
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,     // current column
    input  logic [PIXEL_BITS-1:0]        new_value,   // sample entering the bottom row
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,     // column of the next cycle
    output logic [PIXEL_BITS-1:0]        top_value,   // upper store at the current column
    output logic [PIXEL_BITS-1:0]        mid_value    // middle store at the current column
);

    logic [PIXEL_BITS-1:0] upper_q;
    logic [PIXEL_BITS-1:0] middle_q;
    logic                  hit_reg;
    logic                  hit_next;
    logic [PIXEL_BITS-1:0] fwd_upper_reg;
    logic [PIXEL_BITS-1:0] fwd_middle_reg;

    // Middle row moves up, new sample becomes the middle row
    nmf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (mid_value),
        .rd_addr (rd_addr),
        .rd_data (upper_q)
    );

    nmf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_middle_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (new_value),
        .rd_addr (rd_addr),
        .rd_data (middle_q)
    );

    // Catch a read of the entry written in the same cycle
    assign hit_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    // Hold the written data for forwarding
    always_ff @(posedge aclk) begin
        fwd_upper_reg  <= mid_value;
        fwd_middle_reg <= new_value;
    end

    assign top_value = hit_reg ? fwd_upper_reg  : upper_q;
    assign mid_value = hit_reg ? fwd_middle_reg : middle_q;

    // A forwarded read always follows a write at that same column
    property p_fwd_after_write;
        @(posedge aclk) disable iff (!aresetn)
        hit_reg |-> $past(wr_en) && ($past(wr_addr) == $past(rd_addr));
    endproperty
    a_fwd_after_write: assert property (p_fwd_after_write)
        else $error("line store forwarding without a matching write");

endmodule

// File: hw/rtl/nmf_window_sum.sv
// 3x3 window registers, neighbour selection with edge replication, operand
// stage, sum of eight and output register. Depends on nmf_pkg.

module nmf_window_sum
    import nmf_pkg::*;
#(
    parameter int PIXEL_BITS = NMF_PIXEL_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  nmf_ctrl_t             ctrl,
    input  logic [PIXEL_BITS-1:0] top_value,
    input  logic [PIXEL_BITS-1:0] mid_value,
    input  logic [PIXEL_BITS-1:0] new_value,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIXEL_BITS-1:0] out_mean,
    output logic                  out_last
);

    localparam int SW = PIXEL_BITS + 3;

    logic [PIXEL_BITS-1:0] win_reg  [3][3];
    logic [PIXEL_BITS-1:0] win_next [3][3];
    logic [PIXEL_BITS-1:0] op_reg   [8];
    logic [PIXEL_BITS-1:0] op_next  [8];
    logic                  a_valid_reg;
    logic                  a_valid_next;
    logic                  a_last_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic                  m_last_reg;
    logic [PIXEL_BITS-1:0] m_mean_reg;
    logic                  advance;
    logic [1:0]            row_t;
    logic [1:0]            row_b;
    logic [1:0]            col_l;
    logic [1:0]            col_r;
    logic [SW-1:0]         sum;

    // Shifted window: columns move left, new column enters on the right
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = top_value;
        win_next[1][2] = mid_value;
        win_next[2][2] = new_value;
    end

    // Pick the eight neighbours out of the shifted window
    always_comb begin
        row_t = ctrl.top_edge    ? 2'd1 : 2'd0;
        row_b = ctrl.bottom_edge ? 2'd1 : 2'd2;
        if (ctrl.first_col) begin
            col_l = ctrl.width_one ? 2'd1 : 2'd0;
            col_r = 2'd1;
        end else begin
            col_l = ctrl.second_col ? 2'd1 : 2'd0;
            col_r = 2'd2;
        end
        op_next[0] = win_next[row_t][col_l];
        op_next[1] = win_next[row_t][1];
        op_next[2] = win_next[row_t][col_r];
        op_next[3] = win_next[1][col_l];
        op_next[4] = win_next[1][col_r];
        op_next[5] = win_next[row_b][col_l];
        op_next[6] = win_next[row_b][1];
        op_next[7] = win_next[row_b][col_r];
    end

    // Advance the window on every accepted transaction that is not a dropped drain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
        end else if (ctrl.shift) begin
            win_reg <= win_next;
        end
    end

    // Handshake of the operand stage and the output register
    assign advance      = !m_valid_reg || out_ready;
    assign in_ready     = !a_valid_reg || advance;
    assign a_valid_next = in_ready ? (ctrl.shift && ctrl.emit) : a_valid_reg;
    assign m_valid_next = advance ? a_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the operands of an emitting transaction
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            op_reg     <= op_next;
            a_last_reg <= ctrl.frame_end;
        end
    end

    // Add the eight neighbours
    always_comb begin
        sum = '0;
        for (int i = 0; i < 8; i++) begin
            sum = sum + SW'(op_reg[i]);
        end
    end

    // Drop three bits and hold the result until taken
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_mean_reg <= sum[SW-1:3];
            m_last_reg <= a_last_reg;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_mean  = m_mean_reg;
    assign out_last  = m_last_reg;

    // An emitting transaction always lands in the operand stage
    property p_emit_loaded;
        @(posedge aclk) disable iff (!aresetn)
        (ctrl.shift && ctrl.emit && in_ready) |=> a_valid_reg;
    endproperty
    a_emit_loaded: assert property (p_emit_loaded)
        else $error("emitting transaction lost before the operand stage");

    // A stalled output keeps its pending operands in place
    property p_stall_holds;
        @(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && m_valid_reg && !out_ready) |=> (a_valid_reg && m_valid_reg);
    endproperty
    a_stall_holds: assert property (p_stall_holds)
        else $error("pending result dropped while the output stalled");

endmodule

// File: hw/rtl/neighbour_mean_3x3_filter.sv
// Top level of the 3x3 neighbour mean filter: configuration registers,
// raster counters and sequencing. Depends on nmf_pkg, nmf_line_store, nmf_window_sum.
//
// Usage:
//   s_* carries one transaction per item: s_tuser is the kind (pixel or drain),
//   s_tdata the pixel sample. Pixels arrive in raster order; after the last
//   pixel of a frame, frame_width + 1 drain transactions flush the final results.
//   m_* carries the results: m_tdata is the mean of the eight neighbours
//   (truncated), m_tlast marks the frame's last pixel. Edges are replicated.
//   cfg_* writes frame_width (index 0) or frame_height (index 1) while the
//   block is idle; a write restarts the frame counters.
// Throughput: one transaction per cycle on s_* while m_* is not stalled.
// Timing: a pixel's result becomes due with the transaction frame_width + 1 slots later
//   and reaches m_* through the operand stage and then the output register.
// Each transaction reads both line stores at the next column, registered,
//   and writes them at the current column; a one-entry forward covers the
//   single-column case.
// Reset clears the counters, the window and the pipeline; the line stores
//   keep undefined contents, which edge replication never lets through.
// A stalled receiver holds the result in the output register; one more result
//   waits in the operand stage, after which s_tready drops.

module neighbour_mean_3x3_filter
    import nmf_pkg::*;
#(
    parameter int MAX_WIDTH  = NMF_MAX_WIDTH,
    parameter int PIXEL_BITS = NMF_PIXEL_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]      s_tdata,   // pixel_value
    input  logic [0:0]                           s_tuser,   // kind
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]      m_tdata,   // mean_value
    output logic                                 m_tlast,   // frame_end
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]              cfg_index,
    input  logic [CFG_DATA_BITS-1:0]             cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int DW = ((PIXEL_BITS + 7) / 8) * 8;

    logic [FW_BITS-1:0]    frame_width_reg;
    logic [FW_BITS-1:0]    frame_width_next;
    logic [FH_BITS-1:0]    frame_height_reg;
    logic [FH_BITS-1:0]    frame_height_next;
    logic                  cfg_hit;
    logic [AW-1:0]         col_reg;
    logic [AW-1:0]         col_next;
    logic [ROW_BITS-1:0]   row_reg;
    logic [ROW_BITS-1:0]   row_next;
    logic [WW-1:0]         eff_w;
    logic [ROW_BITS-1:0]   eff_h;
    logic [WW-1:0]         col_inc;
    logic                  accept;
    logic                  drain_phase;
    logic                  drop;
    logic                  wrap;
    logic [PIXEL_BITS-1:0] new_value;
    logic [PIXEL_BITS-1:0] top_value;
    logic [PIXEL_BITS-1:0] mid_value;
    logic [PIXEL_BITS-1:0] out_mean;
    logic                  win_ready;
    nmf_ctrl_t             ctrl;

    // Decode configuration writes
    assign cfg_ready = 1'b1;

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        cfg_hit           = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH: begin
                    frame_width_next = cfg_data[FW_BITS-1:0];
                    cfg_hit          = 1'b1;
                end
                REG_FRAME_HEIGHT: begin
                    frame_height_next = cfg_data[FH_BITS-1:0];
                    cfg_hit           = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // Clamp the frame width to what the line stores hold; a zero size counts as one
    always_comb begin
        if (frame_width_reg == '0) begin
            eff_w = WW'(1);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(frame_width_reg);
        end
        eff_h = (frame_height_reg == '0) ? ROW_BITS'(1) : ROW_BITS'(frame_height_reg);
    end

    // Classify the incoming transaction
    assign accept      = s_tvalid && s_tready;
    assign drain_phase = row_reg >= eff_h;
    assign drop        = (s_tuser[0] == KIND_DRAIN) && !drain_phase;
    assign new_value   = drain_phase ? '0 : s_tdata[PIXEL_BITS-1:0];
    assign col_inc     = WW'(col_reg) + WW'(1);
    assign wrap        = col_inc >= eff_w;

    // Build the control word for the window unit
    always_comb begin
        ctrl.shift       = accept && !drop;
        ctrl.first_col   = (col_reg == '0);
        ctrl.second_col  = (col_reg == AW'(1));
        ctrl.width_one   = (eff_w == WW'(1));
        ctrl.emit        = (row_reg >= ROW_BITS'(2))
                           || ((row_reg == ROW_BITS'(1)) && !ctrl.first_col);
        ctrl.top_edge    = ctrl.first_col ? (row_reg == ROW_BITS'(2))
                                          : (row_reg == ROW_BITS'(1));
        ctrl.bottom_edge = ctrl.first_col ? (row_reg >= eff_h + ROW_BITS'(1))
                                          : (row_reg >= eff_h);
        ctrl.frame_end   = ctrl.emit && ctrl.first_col
                           && (row_reg == eff_h + ROW_BITS'(1));
    end

    // Advance the raster counters, restart on frame end or configuration
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (ctrl.shift) begin
            if (ctrl.frame_end) begin
                col_next = '0;
                row_next = '0;
            end else if (wrap) begin
                col_next = '0;
                row_next = row_reg + ROW_BITS'(1);
            end else begin
                col_next = col_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    nmf_line_store #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_line_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (ctrl.shift),
        .wr_addr   (col_reg),
        .new_value (new_value),
        .rd_addr   (col_next),
        .top_value (top_value),
        .mid_value (mid_value)
    );

    nmf_window_sum #(.PIXEL_BITS(PIXEL_BITS)) u_window_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .top_value (top_value),
        .mid_value (mid_value),
        .new_value (new_value),
        .in_ready  (win_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_mean  (out_mean),
        .out_last  (m_tlast)
    );

    assign s_tready = win_ready;
    assign m_tdata  = DW'(out_mean);

    // Column stays inside the frame width
    property p_col_in_range;
        @(posedge aclk) disable iff (!aresetn)
        WW'(col_reg) < eff_w;
    endproperty
    a_col_in_range: assert property (p_col_in_range)
        else $error("column counter beyond frame width");

    // Row never runs past the drain rows
    property p_row_in_range;
        @(posedge aclk) disable iff (!aresetn)
        row_reg <= eff_h + ROW_BITS'(1);
    endproperty
    a_row_in_range: assert property (p_row_in_range)
        else $error("row counter beyond the drain rows");

    // The frame's last result restarts the raster
    property p_restart_after_end;
        @(posedge aclk) disable iff (!aresetn)
        (ctrl.shift && ctrl.frame_end) |=> (col_reg == '0) && (row_reg == '0);
    endproperty
    a_restart_after_end: assert property (p_restart_after_end)
        else $error("counters did not restart after the frame end");

endmodule

// File: sim/nmf_result_checker.sv
// Result checker for the 3x3 neighbour mean filter testbench.
// Watches the pixel, result and register channels, predicts every result and
// compares it with what the block returns. Depends on nmf_pkg.

module nmf_result_checker
    import nmf_pkg::*;
#(
    parameter int MAX_WIDTH  = NMF_MAX_WIDTH,
    parameter int PIXEL_BITS = NMF_PIXEL_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]   s_tdata,   // pixel_value
    input  logic [0:0]                        s_tuser,   // kind
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]   m_tdata,   // mean_value
    input  logic                              m_tlast,   // frame_end
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]           cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          cfg_data,
    output int                                mismatch_count,
    output int                                pending_results
);

    localparam int SUM_W = PIXEL_BITS + 3;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    typedef struct packed {
        pixel_t mean;
        logic   frame_end;
    } mean_result_t;

    // Shadow copy of the filter state
    pixel_t             upper_row [MAX_WIDTH];
    pixel_t             middle_row [MAX_WIDTH];
    pixel_t             win [3][3];          // [row above/centre/below][column]
    int unsigned        col_cnt;
    int unsigned        row_cnt;
    int unsigned        out_pos;
    logic [FW_BITS-1:0] width_reg;
    logic [FH_BITS-1:0] height_reg;

    mean_result_t       expected_means[$];
    int                 mismatches = 0;
    int                 outstanding = 0;

    assign mismatch_count  = mismatches;
    assign pending_results = outstanding;

    function automatic int unsigned active_width();
        if (width_reg == '0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        return (height_reg == '0) ? 1 : 32'(height_reg);
    endfunction

    function automatic void restart_frame();
        col_cnt = 0;
        row_cnt = 0;
        out_pos = 0;
    endfunction

    // Sum the eight neighbours held in the window, replicating the centre row
    // at the top and bottom edges, and truncate the mean.
    function automatic pixel_t ring_mean(input int lc, input int mc, input int rc,
                                         input int unsigned r, input int unsigned h);
        int               tr;
        int               br;
        logic [SUM_W-1:0] sum;
        tr  = (r == 0) ? 1 : 0;
        br  = (r + 1 >= h) ? 1 : 2;
        sum = SUM_W'(win[tr][lc]) + SUM_W'(win[tr][mc]) + SUM_W'(win[tr][rc])
            + SUM_W'(win[1][lc]) + SUM_W'(win[1][rc])
            + SUM_W'(win[br][lc]) + SUM_W'(win[br][mc]) + SUM_W'(win[br][rc]);
        return sum[SUM_W-1:3];
    endfunction

    // Advance the shadow state by one accepted transaction; return 1 when it
    // produces a result.
    function automatic bit next_mean(input logic kind, input pixel_t px,
                                     output mean_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        bit          emit;
        pixel_t      top_px;
        pixel_t      mid_px;
        pixel_t      new_px;
        int          k;
        w   = active_width();
        h   = active_height();
        r   = row_cnt;
        c   = col_cnt;
        res = '0;
        if (c >= w) c = 0;
        // Drop a drain that arrives while pixels are still due
        if (r < h && kind == KIND_DRAIN) return 0;

        emit   = (r >= 2) || (r == 1 && c >= 1);
        new_px = (r >= h) ? '0 : px;

        // Last column of a row: use the window before it shifts
        if (emit && c == 0) res.mean = ring_mean(w == 1 ? 2 : 1, 2, 2, r - 2, h);

        top_px        = upper_row[c];
        mid_px        = middle_row[c];
        upper_row[c]  = mid_px;
        middle_row[c] = new_px;
        for (k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top_px;
        win[1][2] = mid_px;
        win[2][2] = new_px;

        if (emit && c >= 1) res.mean = ring_mean(c == 1 ? 1 : 0, 1, 2, r - 1, h);

        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        col_cnt = c;
        row_cnt = r;

        if (!emit) return 0;
        res.frame_end = (out_pos + 1 == w * h);
        out_pos++;
        if (res.frame_end) restart_frame();
        return 1;
    endfunction

    // Follow every transaction on the three channels
    always @(posedge aclk) begin
        mean_result_t predicted;
        mean_result_t oldest;
        int           i;
        if (!aresetn) begin
            for (i = 0; i < MAX_WIDTH; i++) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            win        = '{default: '0};
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            restart_frame();
            expected_means.delete();
        end else begin
            // Register write: take the value and restart the frame
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FRAME_WIDTH) begin
                    width_reg = cfg_data[FW_BITS-1:0];
                    restart_frame();
                end else if (cfg_index == REG_FRAME_HEIGHT) begin
                    height_reg = cfg_data[FH_BITS-1:0];
                    restart_frame();
                end
            end

            if (s_tvalid && s_tready) begin
                if (next_mean(s_tuser[0], s_tdata[PIXEL_BITS-1:0], predicted))
                    expected_means.push_back(predicted);
            end

            // Compare each returned result with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_means.size() == 0) begin
                    $error("unexpected result: mean_value %0d frame_end %0b",
                           m_tdata[PIXEL_BITS-1:0], m_tlast);
                    mismatches++;
                end else begin
                    oldest = expected_means.pop_front();
                    if (m_tdata[PIXEL_BITS-1:0] !== oldest.mean) begin
                        $error("mean_value: expected %0d, actual %0d",
                               oldest.mean, m_tdata[PIXEL_BITS-1:0]);
                        mismatches++;
                    end
                    if (m_tlast !== oldest.frame_end) begin
                        $error("frame_end: expected %0b, actual %0b",
                               oldest.frame_end, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = expected_means.size();
    end

endmodule

// File: sim/tb_neighbour_mean_3x3_filter.sv
// Testbench top for the 3x3 neighbour mean filter: clock, reset, frame and
// register stimulus, and the verdict. Depends on nmf_pkg, the filter RTL and
// nmf_result_checker, which predicts and compares every result.

module tb_neighbour_mean_3x3_filter;
    import nmf_pkg::*;

    localparam int DATA_W        = ((NMF_PIXEL_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 600;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [DATA_W-1:0]        s_tdata   = '0;   // pixel_value
    logic [0:0]               s_tuser   = '0;   // kind
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [DATA_W-1:0]        m_tdata;          // mean_value
    logic                     m_tlast;          // frame_end
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    int                       mismatch_count;
    int                       pending_results;

    int unsigned              cycle_count   = 0;
    int                       active_w      = 4;   // effective frame geometry
    int                       active_h      = 4;
    int                       sent_items    = 0;
    bit                       source_steady = 1'b0;
    bit                       sink_steady   = 1'b0;
    int                       stall_left    = 0;
    int                       sink_phase    = 0;

    neighbour_mean_3x3_filter u_dut (.*);

    nmf_result_checker u_checker (.*);

    always begin
        #5;
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result receiver: short and long stalls, with calm stretches between
    always @(posedge aclk) begin
        if (sink_phase == 0) begin
            sink_steady = ($urandom_range(0, 3) == 0);
            sink_phase  = $urandom_range(200, 800);
        end else begin
            sink_phase--;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!sink_steady && $urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 80)
                                                     : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic int source_gap();
        int roll;
        if (source_steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic logic [DATA_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DATA_W'({NMF_PIXEL_BITS{1'b1}});
            default: return DATA_W'(NMF_PIXEL_BITS'($urandom));
        endcase
    endfunction

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_item(input logic kind, input logic [DATA_W-1:0] value);
        int gap;
        gap = source_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        sent_items++;
    endtask

    // Stop the source and wait until every predicted result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
    endtask

    // Write both geometry registers while the block is idle
    task automatic configure(input int width, input int height);
        settle();
        put_reg(REG_FRAME_WIDTH, width);
        put_reg(REG_FRAME_HEIGHT, height);
        cfg_valid <= 1'b0;
        active_w  = (width == 0) ? 1 : ((width > NMF_MAX_WIDTH) ? NMF_MAX_WIDTH : width);
        active_h  = (height == 0) ? 1 : height;
    endtask

    // Send a frame in raster order with stray drains, then the flush tail.
    // A frame cut short gets no tail and needs a restart afterwards.
    task automatic run_frame(input int stop_after, input int stray_pct);
        int pixels;
        int k;
        pixels = active_w * active_h;
        for (k = 0; k < pixels && k < stop_after; k++) begin
            if ($urandom_range(0, 99) < stray_pct) send_item(KIND_DRAIN, random_pixel());
            send_item(KIND_PIXEL, random_pixel());
        end
        if (stop_after < pixels) return;
        // frame_width + 1 flush slots; a pixel here acts as a drain
        for (k = 0; k <= active_w; k++)
            send_item(($urandom_range(0, 3) == 0) ? KIND_PIXEL : KIND_DRAIN, random_pixel());
    endtask

    function automatic int pick_width();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return $urandom_range(1, 6);
        if (roll < 90) return $urandom_range(7, 24);
        if (roll < 98) return $urandom_range(25, 64);
        return $urandom_range(65, 200);
    endfunction

    function automatic int pick_height(input int width);
        int roll;
        if (width > 64) return $urandom_range(1, 3);
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 5);
        if (roll < 95) return $urandom_range(6, 10);
        return $urandom_range(11, 20);
    endfunction

    initial begin
        int  k;
        int  random_start;
        int  width;
        bit  need_restart;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset geometry 4x4: a drain before any pixel, full-scale pixels with
        // one zero, a drain in mid-frame, pixels in the flush tail and a drain
        // after the frame has ended
        send_item(KIND_DRAIN, '0);
        for (k = 0; k < 16; k++) begin
            if (k == 8) send_item(KIND_DRAIN, '1);
            send_item(KIND_PIXEL, (k == 5) ? '0 : DATA_W'({NMF_PIXEL_BITS{1'b1}}));
        end
        send_item(KIND_PIXEL, '1);
        send_item(KIND_DRAIN, '0);
        send_item(KIND_PIXEL, '0);
        send_item(KIND_DRAIN, '1);
        send_item(KIND_DRAIN, '0);
        send_item(KIND_DRAIN, '1);

        // Geometry extremes: single pixel, zero registers, wide and tall frames
        configure(1, 1);
        run_frame(1, 0);
        configure(0, 0);
        run_frame(1, 20);
        configure(2, 3);
        run_frame(6, 10);
        run_frame(6, 0);
        configure(2047, 3);
        run_frame(1024 + 40, 1);
        configure(1, 4095);
        run_frame(40, 1);
        configure(3, 4095);
        run_frame(50, 5);

        // Random geometry with back-to-back frames; some frames cut short
        random_start = sent_items;
        need_restart = 1'b1;
        while (sent_items - random_start < RANDOM_ITEMS) begin
            if (need_restart || $urandom_range(0, 2) == 0) begin
                width = pick_width();
                configure(width, pick_height(width));
            end
            source_steady = ($urandom_range(0, 4) == 0);
            need_restart  = ($urandom_range(0, 9) == 0);
            if (need_restart)
                run_frame($urandom_range(0, active_w * active_h - 1), 5);
            else
                run_frame(active_w * active_h, 4);
        end

        settle();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
